[src/lpfd_pkg.sv]
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants of the length-prefixed deframer
// Result record, result kind and error codes, and the CRC-16/ARC byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_CRC        = 2'd1;

  localparam logic [31:0] MAX_FRAME_LENGTH_RST = 32'd65536;
  localparam logic [31:0] MIN_FRAME_LENGTH     = 32'd7;
  localparam logic [7:0]  NAME_TERMINATOR      = 8'h00;
  localparam logic [15:0] CRC_POLY_REFL        = 16'hA001;

  // result kinds
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd2;
  localparam logic [2:0] ERR_NAME      = 3'd3;
  localparam logic [2:0] ERR_CRC       = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       frame_end;
  } result_t;

  // CRC-16/ARC, reflected, one byte per call
  function automatic logic [15:0] crc_arc_update(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/length_prefixed_frame_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte-stream deframer with CRC-16/ARC check
// Parses length / name / body / checksum frames and reports each content
// byte and the accept or reject verdict of every frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and produces at most one result
// per byte. The whole per-byte step (CRC-16/ARC byte update, length assembly
// and the 32-bit position and limit compares) completes in the cycle the byte
// is accepted, and the result lands in a two-entry output buffer, so a byte
// enters in every cycle while the downstream side takes results; the input
// stalls only once both buffer entries hold results that are not yet taken.
// After any reject the block stays closed and drops bytes until reset.
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     data_byte,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_kind,
  output logic [7:0]                          out_byte,
  output logic [2:0]                          reject_code,
  output logic                                frame_end,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lpfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  import lpfd_pkg::*;

  // parse phases
  localparam logic [2:0] PH_LENGTH = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_CRC_LO = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;

  logic [31:0] max_frame_length;
  logic        check_crc;

  logic [2:0]  phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic        closed, closed_next;

  logic        res_valid;
  result_t     res;

  result_t     head, skid;
  logic        skid_valid;

  logic        take, produce, head_free;
  logic [15:0] crc_upd;
  logic [31:0] pos_inc;
  logic [31:0] len_full;
  logic [15:0] rx_crc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign take      = in_valid && !in_stall;
  assign produce   = take && res_valid;
  assign head_free = !out_valid || !out_stall;

  assign crc_upd  = crc_arc_update(running_crc, data_byte);
  assign pos_inc  = byte_position + 32'd1;
  assign len_full = {data_byte, frame_length[23:0]};
  assign rx_crc   = {data_byte, crc_low_byte};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_LENGTH_RST;
      check_crc        <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
        CFG_CHECK_CRC:        check_crc        <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  // per-byte parse step
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    running_crc_next   = running_crc;
    crc_low_byte_next  = crc_low_byte;
    closed_next        = closed;
    res_valid          = 1'b0;
    res                = '{kind: KIND_NAME, data: 8'h00, err: ERR_NONE, frame_end: 1'b0};

    if (!closed) begin
      unique case (phase)
        PH_LENGTH: begin
          running_crc_next   = crc_upd;
          byte_position_next = pos_inc;
          unique case (byte_position[1:0])
            2'd0: frame_length_next = {frame_length[31:8], data_byte};
            2'd1: frame_length_next = {frame_length[31:16], data_byte, frame_length[7:0]};
            2'd2: frame_length_next = {frame_length[31:24], data_byte, frame_length[15:0]};
            default: frame_length_next = len_full;
          endcase
          if (byte_position[1:0] == 2'd3) begin
            if (len_full > max_frame_length) begin
              res_valid   = 1'b1;
              res         = '{kind: KIND_REJECT, data: 8'h00, err: ERR_TOO_LONG,
                              frame_end: 1'b1};
              closed_next = 1'b1;
            end else if (len_full < MIN_FRAME_LENGTH) begin
              res_valid   = 1'b1;
              res         = '{kind: KIND_REJECT, data: 8'h00, err: ERR_TOO_SHORT,
                              frame_end: 1'b1};
              closed_next = 1'b1;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end

        PH_NAME: begin
          running_crc_next = crc_upd;
          if (data_byte == NAME_TERMINATOR) begin
            byte_position_next = pos_inc;
            phase_next = (pos_inc == frame_length - 32'd2) ? PH_CRC_LO : PH_BODY;
          end else if (byte_position == frame_length - 32'd3) begin
            // name fills its region with no terminator
            res_valid   = 1'b1;
            res         = '{kind: KIND_REJECT, data: 8'h00, err: ERR_NAME, frame_end: 1'b1};
            closed_next = 1'b1;
          end else begin
            byte_position_next = pos_inc;
            res_valid = 1'b1;
            res       = '{kind: KIND_NAME, data: data_byte, err: ERR_NONE, frame_end: 1'b0};
          end
        end

        PH_BODY: begin
          running_crc_next   = crc_upd;
          byte_position_next = pos_inc;
          if (pos_inc == frame_length - 32'd2) begin
            phase_next = PH_CRC_LO;
          end
          res_valid = 1'b1;
          res       = '{kind: KIND_BODY, data: data_byte, err: ERR_NONE, frame_end: 1'b0};
        end

        PH_CRC_LO: begin
          crc_low_byte_next  = data_byte;
          byte_position_next = pos_inc;
          phase_next         = PH_CRC_HI;
        end

        PH_CRC_HI: begin
          res_valid = 1'b1;
          if (check_crc && (rx_crc != running_crc)) begin
            res         = '{kind: KIND_REJECT, data: 8'h00, err: ERR_CRC, frame_end: 1'b1};
            closed_next = 1'b1;
          end else begin
            res                = '{kind: KIND_ACCEPT, data: 8'h00, err: ERR_NONE,
                                   frame_end: 1'b1};
            phase_next         = PH_LENGTH;
            byte_position_next = '0;
            frame_length_next  = '0;
            running_crc_next   = '0;
            crc_low_byte_next  = '0;
          end
        end

        default: begin
          phase_next         = PH_LENGTH;
          byte_position_next = '0;
          frame_length_next  = '0;
          running_crc_next   = '0;
          crc_low_byte_next  = '0;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LENGTH;
      byte_position <= '0;
      frame_length  <= '0;
      running_crc   <= '0;
      crc_low_byte  <= '0;
      closed        <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      running_crc   <= running_crc_next;
      crc_low_byte  <= crc_low_byte_next;
      closed        <= closed_next;
    end
  end

  // two-entry result buffer: head drives the ports, skid catches overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        head <= skid;
      end else if (produce) begin
        head <= res;
      end
    end else if (produce) begin
      skid <= res;
    end
  end

  assign out_kind    = head.kind;
  assign out_byte    = head.data;
  assign reject_code = head.err;
  assign frame_end   = head.frame_end;

  // checks
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while head entry empty");

  a_closed_after_reject: assert property (@(posedge clk) disable iff (rst)
    (produce && res.kind == KIND_REJECT) |=> closed)
    else $error("stream not closed after a reject");

  a_end_marks_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end == (out_kind == KIND_ACCEPT || out_kind == KIND_REJECT)))
    else $error("frame_end does not match result kind");

  a_no_result_when_closed: assert property (@(posedge clk) disable iff (rst)
    closed |-> !produce)
    else $error("result produced while stream closed");

endmodule

`default_nettype wire
